>>> rtl/core/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ascp_pkg: shared definitions for the Ascon permutation
// Widths, rotation amounts, round constants, command codes and the small
// structs that carry controls to the column cells and taps between them.
// ----------------------------------------------------------------------------
`default_nettype none

package ascp_pkg;

  localparam int LANES      = 5;
  localparam int LANE_W     = 64;
  localparam int ROUNDS     = 12;
  localparam int ROUND_W    = 4;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  // Command codes; the unused code runs like the 6-round form.
  localparam logic [1:0] CMD_P12 = 2'd0;
  localparam logic [1:0] CMD_P8  = 2'd1;
  localparam logic [1:0] CMD_P6  = 2'd2;

  localparam logic [ROUND_W-1:0] FIRST_P12 = ROUND_W'(0);
  localparam logic [ROUND_W-1:0] FIRST_P8  = ROUND_W'(4);
  localparam logic [ROUND_W-1:0] FIRST_P6  = ROUND_W'(6);

  // Right-rotation amounts of the linear layer, per lane.
  localparam int ROT_A [LANES] = '{19, 61, 1, 10, 7};
  localparam int ROT_B [LANES] = '{28, 39, 6, 17, 41};

  localparam logic [7:0] RC_TABLE [ROUNDS] = '{
    8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ascp_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ascp_ctl_t;

  // Bits taken from the two rotated positions of every lane.
  typedef struct packed {
    logic [LANES-1:0] a;
    logic [LANES-1:0] b;
  } ascp_tap_t;

  function automatic logic [ROUND_W-1:0] first_round(input logic [1:0] cmd);
    logic [ROUND_W-1:0] r;
    case (cmd)
      CMD_P12: r = FIRST_P12;
      CMD_P8:  r = FIRST_P8;
      CMD_P6:  r = FIRST_P6;
      default: r = FIRST_P6;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ascp_cell.sv
// ----------------------------------------------------------------------------
// ascp_cell: one bit column of the Ascon state
// Holds the five state bits of one column, adds its round constant bit,
// runs the 5-bit S-box and takes its next value from the rotated taps.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_cell
  import ascp_pkg::*;
(
  input  wire logic             clk,
  input  wire ascp_ctl_t        ctl,
  input  wire logic [LANES-1:0] in_col,
  input  wire logic             rc_bit,
  input  wire ascp_tap_t        tap,
  output logic [LANES-1:0]      col_o,
  output logic [LANES-1:0]      sb_o
);

  logic [LANES-1:0] col_r;
  logic [LANES-1:0] col_nxt;

  always_comb begin
    logic [LANES-1:0] w;
    logic [LANES-1:0] t;
    w    = col_r;
    w[2] = w[2] ^ rc_bit;
    w[0] = w[0] ^ w[4];
    w[4] = w[4] ^ w[3];
    w[2] = w[2] ^ w[1];
    t[0] = w[0] ^ (~w[1] & w[2]);
    t[1] = w[1] ^ (~w[2] & w[3]);
    t[2] = w[2] ^ (~w[3] & w[4]);
    t[3] = w[3] ^ (~w[4] & w[0]);
    t[4] = w[4] ^ (~w[0] & w[1]);
    sb_o[0] = t[0] ^ t[4];
    sb_o[1] = t[1] ^ t[0];
    sb_o[2] = ~t[2];
    sb_o[3] = t[3] ^ t[2];
    sb_o[4] = t[4];
  end

  always_comb begin
    col_nxt = col_r;
    if (ctl.load) begin
      col_nxt = in_col;
    end else if (ctl.step) begin
      col_nxt = sb_o ^ tap.a ^ tap.b;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  assign col_o = col_r;

endmodule

`default_nettype wire

>>> rtl/core/ascp_ctrl.sv
// ----------------------------------------------------------------------------
// ascp_ctrl: round sequencer
// Accepts requests, counts rounds from the first constant of the selected
// form up to the last one and flags the finished state for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_ctrl
  import ascp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_cmd,
  output logic            busy,
  output logic            out_valid,
  output ascp_ctl_t       ctl,
  output logic [7:0]      rc
);

  ascp_state_t        state_r;
  ascp_state_t        state_nxt;
  logic [ROUND_W-1:0] round_r;
  logic [ROUND_W-1:0] round_nxt;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (start) begin
          state_nxt = ST_RUN;
          round_nxt = first_round(in_cmd);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        // The counter stops on the last round so that the constant table
        // is never read past its end.
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_DONE;
        end else begin
          round_nxt = round_r + ROUND_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state_r == ST_RUN);
    out_valid = (state_r == ST_DONE);
    ctl.load  = start && (state_r != ST_RUN);
    ctl.step  = (state_r == ST_RUN);
    rc        = RC_TABLE[round_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ascon_permutation.sv
// ----------------------------------------------------------------------------
// ascon_permutation: Ascon p12 / p8 / p6 permutation, one round per cycle
// A row of 64 column cells holds the 320-bit state; a small sequencer
// steps the rounds and hands the round constant to the low cells.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// in_cmd selects the form: 0 runs 12 rounds, 1 runs 8 rounds and 2 runs
// 6 rounds; the unused code 3 also runs the 6-round form. The five 64-bit
// lanes are loaded into the cell row at that edge.
// One round is applied per cycle, and busy stays high while the rounds run.
// The permuted state then sits on the out_lane ports for exactly one cycle,
// marked by out_valid, and the receiver has to take it in that cycle.
// busy is already low while out_valid is high, so a new request can be
// taken in the result cycle; the cell row holds a single state, so no new
// request is taken while a run is still in progress.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any request in flight; the state bits themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_permutation
  import ascp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [LANE_W-1:0] in_lane0_in,
  input  wire logic [LANE_W-1:0] in_lane1_in,
  input  wire logic [LANE_W-1:0] in_lane2_in,
  input  wire logic [LANE_W-1:0] in_lane3_in,
  input  wire logic [LANE_W-1:0] in_lane4_in,
  output logic                   out_valid,
  output logic [LANE_W-1:0]      out_lane0_out,
  output logic [LANE_W-1:0]      out_lane1_out,
  output logic [LANE_W-1:0]      out_lane2_out,
  output logic [LANE_W-1:0]      out_lane3_out,
  output logic [LANE_W-1:0]      out_lane4_out
);

  ascp_ctl_t  ctl;
  logic [7:0] rc;

  // Column outputs of every cell: held state bits and S-box result bits.
  logic [LANES-1:0] col_w [LANE_W];
  logic [LANES-1:0] sb_w  [LANE_W];

  ascp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .rc        (rc)
  );

  // Each cell j gets the S-box bits of the cells that the two right
  // rotations of its lane bring to bit position j.
  for (genvar j = 0; j < LANE_W; j++) begin : g_col
    ascp_tap_t        tap;
    logic [LANES-1:0] in_col;
    logic             rc_bit;

    for (genvar i = 0; i < LANES; i++) begin : g_tap
      assign tap.a[i] = sb_w[(j + ROT_A[i]) % LANE_W][i];
      assign tap.b[i] = sb_w[(j + ROT_B[i]) % LANE_W][i];
    end

    assign in_col = {in_lane4_in[j], in_lane3_in[j], in_lane2_in[j],
                     in_lane1_in[j], in_lane0_in[j]};

    // The round constant only touches the low byte of lane 2.
    if (j < 8) begin : g_rc
      assign rc_bit = rc[j];
    end else begin : g_norc
      assign rc_bit = 1'b0;
    end

    ascp_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .in_col (in_col),
      .rc_bit (rc_bit),
      .tap    (tap),
      .col_o  (col_w[j]),
      .sb_o   (sb_w[j])
    );

    assign out_lane0_out[j] = col_w[j][0];
    assign out_lane1_out[j] = col_w[j][1];
    assign out_lane2_out[j] = col_w[j][2];
    assign out_lane3_out[j] = col_w[j][3];
    assign out_lane4_out[j] = col_w[j][4];
  end

endmodule

`default_nettype wire

>>> rtl/core/ascp_chk.sv
// ----------------------------------------------------------------------------
// ascp_chk: port-level checks for the Ascon permutation
// Watches the request and result handshake over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // An accepted request always starts a run of rounds.
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A run ends only by presenting its result.
  a_run_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("busy dropped without a result");

  // Each result lasts one cycle.
  a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result held longer than one cycle");

  // A result follows a run and the block is ready while showing it.
  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a preceding run");

endmodule

bind ascon_permutation ascp_chk u_chk (.*);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Ascon p12 / p8 / p6 permutation
// A queue of requests, first a short directed list and then random states
// and round counts, feeds a clocked driver that leaves random idle gaps
// between requests. A clocked monitor compares each result, lane by lane,
// with a result computed by the bench's own model of the permutation.
// ----------------------------------------------------------------------------

module tb_top
  import ascp_pkg::*;
;

  // Lane i of a state sits at index i, so lanes[0] is x0.
  typedef logic [LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic [1:0] cmd;
    lanes_t     lanes;
  } perm_req_t;

  // The fourth command code has no name in the package. The block runs it
  // as the 6-round form.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int NUM_RANDOM   = 1400;
  localparam int MAX_REPORTS  = 10;
  // This outlasts a run of the longest form and its result, so it
  // leaves plenty of room for a late or stray result to show up.
  localparam int DRAIN_CYCLES = 30;

  // The bench keeps its own copy of the round constants and of the
  // rotation amounts, so that an error in the shared package cannot hide.
  localparam logic [7:0] RC_SEQ [12] = '{
    8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
  };
  localparam int SHIFT_A [LANES] = '{19, 61, 1, 10, 7};
  localparam int SHIFT_B [LANES] = '{28, 39, 6, 17, 41};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = 2'd0;
  logic [LANE_W-1:0] in_lane0_in = '0;
  logic [LANE_W-1:0] in_lane1_in = '0;
  logic [LANE_W-1:0] in_lane2_in = '0;
  logic [LANE_W-1:0] in_lane3_in = '0;
  logic [LANE_W-1:0] in_lane4_in = '0;
  logic              out_valid;
  logic [LANE_W-1:0] out_lane0_out;
  logic [LANE_W-1:0] out_lane1_out;
  logic [LANE_W-1:0] out_lane2_out;
  logic [LANE_W-1:0] out_lane3_out;
  logic [LANE_W-1:0] out_lane4_out;

  // Requests that wait for the driver, and permuted states that wait for
  // the monitor, oldest first.
  perm_req_t request_q[$];
  lanes_t    permuted_q[$];

  int idle_left = 0;
  int calm_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};

  ascon_permutation DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_lane0_in   (in_lane0_in),
    .in_lane1_in   (in_lane1_in),
    .in_lane2_in   (in_lane2_in),
    .in_lane3_in   (in_lane3_in),
    .in_lane4_in   (in_lane4_in),
    .out_valid     (out_valid),
    .out_lane0_out (out_lane0_out),
    .out_lane1_out (out_lane1_out),
    .out_lane2_out (out_lane2_out),
    .out_lane3_out (out_lane3_out),
    .out_lane4_out (out_lane4_out)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the permutation
  // --------------------------------------------------------------------------

  function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] v, input int s);
    return (v >> s) | (v << (LANE_W - s));
  endfunction

  // One round: the constant goes into x2, then the bitsliced S-box runs
  // across the five lanes, then each lane is mixed with two rotations of
  // itself.
  function automatic lanes_t apply_round(input lanes_t w, input logic [7:0] rc);
    logic [LANE_W-1:0] x0, x1, x2, x3, x4;
    logic [LANE_W-1:0] t0, t1, t2, t3, t4;
    lanes_t            s;
    x0 = w[0];
    x1 = w[1];
    x2 = w[2] ^ {56'd0, rc};
    x3 = w[3];
    x4 = w[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    s[0] = x0 ^ t1;
    s[1] = x1 ^ t2;
    s[2] = x2 ^ t3;
    s[3] = x3 ^ t4;
    s[4] = x4 ^ t0;
    s[1] = s[1] ^ s[0];
    s[0] = s[0] ^ s[4];
    s[3] = s[3] ^ s[2];
    s[2] = ~s[2];
    for (int i = 0; i < LANES; i++) begin
      s[i] = s[i] ^ rotr(s[i], SHIFT_A[i]) ^ rotr(s[i], SHIFT_B[i]);
    end
    return s;
  endfunction

  // The shorter forms run the tail of the 12-round constant sequence.
  function automatic lanes_t ascon_permute(input perm_req_t req);
    lanes_t w;
    int     first;
    case (req.cmd)
      CMD_P12: first = 0;
      CMD_P8:  first = 4;
      default: first = 6;
    endcase
    w = req.lanes;
    for (int r = first; r < 12; r++) begin
      w = apply_round(w, RC_SEQ[r]);
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly dense random lanes, with some all-zero, all-one, single-bit and
  // all-but-one-bit lanes mixed in so sparse states go through the rounds.
  function automatic logic [LANE_W-1:0] random_lane();
    logic [LANE_W-1:0] one_bit;
    one_bit = 64'd1 << $urandom_range(0, LANE_W - 1);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return one_bit;
      3:       return ~one_bit;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Idle cycles before the next request. Most gaps are short, some reach
  // across every round of the longest form, and now and then a stretch of
  // back-to-back requests runs with no idling at all.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 13);
    return $urandom_range(14, 40);
  endfunction

  task automatic report_mismatch(input string what, input int lane,
                                 input logic [LANE_W-1:0] want,
                                 input logic [LANE_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s, lane %0d: expected %h, got %h", $time, what, lane, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // The request on the ports is taken at an edge where start is high and
  // busy is low. Those are the values sampled here, since both change only
  // through nonblocking updates. A taken request has its permuted state
  // queued for the monitor. Then the next request, if any, goes onto the
  // ports once its idle gap has run out. start is assigned at most once per
  // edge, so a request that follows another at once keeps start high.
  always @(posedge clk) begin : driver
    perm_req_t nxt;
    logic      taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        nxt.cmd   = in_cmd;
        nxt.lanes = {in_lane4_in, in_lane3_in, in_lane2_in, in_lane1_in, in_lane0_in};
        permuted_q.push_back(ascon_permute(nxt));
        cmd_seen[in_cmd]++;
        idle_left = pick_gap();
      end
      if (taken || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          in_cmd      <= nxt.cmd;
          in_lane0_in <= nxt.lanes[0];
          in_lane1_in <= nxt.lanes[1];
          in_lane2_in <= nxt.lanes[2];
          in_lane3_in <= nxt.lanes[3];
          in_lane4_in <= nxt.lanes[4];
          start       <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  // A result is valid for one cycle only and is taken at the edge that ends
  // that cycle, so the strobe and the lanes are sampled at every edge. Each
  // lane of the result is checked against the oldest permuted state queued.
  always @(posedge clk) begin : monitor
    lanes_t got;
    lanes_t want;
    if (rst_n) begin
      got = {out_lane4_out, out_lane3_out, out_lane2_out, out_lane1_out, out_lane0_out};
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown", 0, '0, '0);
      end else if (out_valid) begin
        if (permuted_q.size() == 0) begin
          report_mismatch("result with no request outstanding", 0, '0, got[0]);
        end else begin
          want = permuted_q.pop_front();
          results_seen++;
          for (int i = 0; i < LANES; i++) begin
            if (got[i] !== want[i]) begin
              report_mismatch("wrong permuted state", i, want[i], got[i]);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request list, reset and end of the run
  // --------------------------------------------------------------------------
  initial begin : sequencer
    perm_req_t req;

    // Every command, the unused code among them, on the all-zero and on
    // the all-one state.
    for (int c = 0; c < 4; c++) begin
      req.cmd   = 2'(c);
      req.lanes = '0;
      request_q.push_back(req);
      req.lanes = '1;
      request_q.push_back(req);
    end
    // Alternating bit patterns, opposite in neighboring lanes.
    for (int c = 0; c < 3; c++) begin
      req.cmd = 2'(c);
      for (int i = 0; i < LANES; i++) begin
        req.lanes[i] = (i % 2 == 0) ? {16{4'hA}} : {16{4'h5}};
      end
      request_q.push_back(req);
    end
    // A single set bit at the top and at the bottom of each lane, so that
    // the rotations wrap from both ends.
    for (int i = 0; i < LANES; i++) begin
      req.cmd      = 2'(i % 3);
      req.lanes    = '0;
      req.lanes[i] = 64'h8000_0000_0000_0000;
      request_q.push_back(req);
      req.cmd      = (i % 2 == 0) ? CMD_SPARE : CMD_P12;
      req.lanes[i] = 64'h0000_0000_0000_0001;
      request_q.push_back(req);
    end

    // Random states under all four command codes.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      req.cmd = 2'($urandom_range(0, 3));
      for (int i = 0; i < LANES; i++) begin
        req.lanes[i] = random_lane();
      end
      request_q.push_back(req);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start || permuted_q.size() != 0) begin
      @(posedge clk);
    end
    // Give a late or extra result the time of one more long permutation.
    repeat (DRAIN_CYCLES) @(posedge clk);

    // A request whose result never came back counts as a failure.
    if (permuted_q.size() != 0) begin
      $display("%0d requests never returned a result", permuted_q.size());
      mismatches += permuted_q.size();
    end

    $display("Covered %0d requests: %0d of 12 rounds, %0d of 8, %0d of 6, %0d with the spare code.",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("Checked %0d permuted states lane by lane, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // The watchdog leaves ample time for a correct run, even with every
  // request on the longest form and the longest gap in front of it.
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
